// ===== sv/psp_pkg.sv =====
// Shared types and constants for the point spherical projection block.
// Holds the payload structs, the CORDIC angle table and the pipeline sizes.
// Used by every module of the block; depends on nothing.
package psp_pkg;

  typedef struct packed {
    logic               last_in_cloud;
    logic signed [15:0] point_z;
    logic signed [15:0] point_y;
    logic signed [15:0] point_x;
  } in_t;

  typedef struct packed {
    logic               last_out;
    logic signed [15:0] proj_z;
    logic signed [15:0] proj_y;
    logic signed [15:0] proj_x;
    logic        [15:0] range;
    logic        [14:0] polar_angle;
    logic signed [15:0] azimuth;
  } out_t;

  // Per-point side information that rides along the pipeline.
  typedef struct packed {
    logic        last;
    logic        sx;
    logic        sy;
    logic        sz;
    logic        zx;
    logic        zy;
    logic        zz;
    logic [16:0] ux;
    logic [16:0] uy;
    logic [16:0] uz;
  } meta_t;

  localparam int CORDIC_N = 24;
  localparam int CORDIC_W = 48;
  localparam int ANG_W    = 32;
  localparam int SQRT_N   = 32;
  localparam int DIV_N    = 16;
  localparam int NUM_W    = 47;

  // Index of the last pipeline stage before the output buffer.
  localparam int LAST_STG = 51;

  // Angles use pi = 2^31.
  localparam logic [ANG_W-1:0] ANG_PI      = 32'h8000_0000;
  localparam logic [ANG_W-1:0] ANG_HALF_PI = 32'h4000_0000;

  // atan(2^-i), pi = 2^31.
  localparam logic [ANG_W-1:0] ATAN_TAB [0:CORDIC_N-1] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  // CORDIC gain for CORDIC_N iterations, Q24.
  localparam logic [24:0] CORDIC_GAIN_Q24 = 25'd27628053;

  localparam logic [14:0] RADIUS_RESET = 15'd1408;

endpackage

// ===== sv/psp_cordic.sv =====
// Pipelined CORDIC in vectoring mode, one iteration per register stage.
// Returns the first-quadrant angle atan(y/x) and the gain-scaled magnitude.
// Depends on psp_pkg.
module psp_cordic import psp_pkg::*; (
  input  logic                       clk,
  input  logic                       adv,
  input  logic signed [CORDIC_W-1:0] x_in,
  input  logic signed [CORDIC_W-1:0] y_in,
  output logic signed [CORDIC_W-1:0] x_out,
  output logic        [ANG_W-1:0]    ang_out
);

  logic signed [CORDIC_W-1:0] x_r   [0:CORDIC_N-1];
  logic signed [CORDIC_W-1:0] y_r   [0:CORDIC_N-1];
  logic signed [ANG_W+1:0]    z_r   [0:CORDIC_N-1];
  logic signed [CORDIC_W-1:0] x_nxt [0:CORDIC_N-1];
  logic signed [CORDIC_W-1:0] y_nxt [0:CORDIC_N-1];
  logic signed [ANG_W+1:0]    z_nxt [0:CORDIC_N-1];

  always_comb begin
    logic signed [CORDIC_W-1:0] xc [0:CORDIC_N-1];
    logic signed [CORDIC_W-1:0] yc [0:CORDIC_N-1];
    logic signed [ANG_W+1:0]    zc [0:CORDIC_N-1];
    logic signed [ANG_W+1:0]    step;
    xc[0] = x_in;
    yc[0] = y_in;
    zc[0] = '0;
    for (int i = 1; i < CORDIC_N; i++) begin
      xc[i] = x_r[i-1];
      yc[i] = y_r[i-1];
      zc[i] = z_r[i-1];
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      step = $signed({2'b00, ATAN_TAB[i]});
      if (yc[i] >= 0) begin
        x_nxt[i] = xc[i] + (yc[i] >>> i);
        y_nxt[i] = yc[i] - (xc[i] >>> i);
        z_nxt[i] = zc[i] + step;
      end else begin
        x_nxt[i] = xc[i] - (yc[i] >>> i);
        y_nxt[i] = yc[i] + (xc[i] >>> i);
        z_nxt[i] = zc[i] - step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < CORDIC_N; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
      end
    end
  end

  assign x_out = x_r[CORDIC_N-1];

  // Clamp the accumulated angle to [0, pi/2].
  always_comb begin
    if (z_r[CORDIC_N-1] < 0) begin
      ang_out = '0;
    end else if (z_r[CORDIC_N-1] > $signed({2'b00, ANG_HALF_PI})) begin
      ang_out = ANG_HALF_PI;
    end else begin
      ang_out = z_r[CORDIC_N-1][ANG_W-1:0];
    end
  end

endmodule

// ===== sv/psp_sqrt.sv =====
// Pipelined restoring square root, one result bit per register stage.
// Computes floor(sqrt(s * 2^32)), the range in Q16. Depends on psp_pkg.
module psp_sqrt import psp_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] s_in,
  output logic [31:0] root_out
);

  logic [31:0] rad_r   [0:SQRT_N-1];
  logic [33:0] rem_r   [0:SQRT_N-1];
  logic [31:0] root_r  [0:SQRT_N-1];
  logic [31:0] rad_nxt [0:SQRT_N-1];
  logic [33:0] rem_nxt [0:SQRT_N-1];
  logic [31:0] root_nxt[0:SQRT_N-1];

  always_comb begin
    logic [31:0] radc  [0:SQRT_N-1];
    logic [33:0] remc  [0:SQRT_N-1];
    logic [31:0] rootc [0:SQRT_N-1];
    logic [35:0] remn;
    logic [35:0] trial;
    radc[0]  = s_in;
    remc[0]  = '0;
    rootc[0] = '0;
    for (int i = 1; i < SQRT_N; i++) begin
      radc[i]  = rad_r[i-1];
      remc[i]  = rem_r[i-1];
      rootc[i] = root_r[i-1];
    end
    for (int i = 0; i < SQRT_N; i++) begin
      remn  = {remc[i], radc[i][31:30]};
      trial = {2'b00, rootc[i], 2'b01};
      rad_nxt[i] = {radc[i][29:0], 2'b00};
      if (remn >= trial) begin
        rem_nxt[i]  = 34'(remn - trial);
        root_nxt[i] = {rootc[i][30:0], 1'b1};
      end else begin
        rem_nxt[i]  = remn[33:0];
        root_nxt[i] = {rootc[i][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < SQRT_N; i++) begin
        rad_r[i]  <= rad_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
      end
    end
  end

  assign root_out = root_r[SQRT_N-1];

endmodule

// ===== sv/psp_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient is known to fit in DIV_N bits. Depends on psp_pkg.
module psp_div import psp_pkg::*; (
  input  logic             clk,
  input  logic             adv,
  input  logic [NUM_W-1:0] num_in,
  input  logic [31:0]      den_in,
  output logic [DIV_N-1:0] quo_out
);

  logic [NUM_W-1:0] rem_r   [0:DIV_N-1];
  logic [31:0]      den_r   [0:DIV_N-1];
  logic [DIV_N-1:0] quo_r   [0:DIV_N-1];
  logic [NUM_W-1:0] rem_nxt [0:DIV_N-1];
  logic [DIV_N-1:0] quo_nxt [0:DIV_N-1];

  always_comb begin
    logic [NUM_W-1:0] remc [0:DIV_N-1];
    logic [31:0]      denc [0:DIV_N-1];
    logic [DIV_N-1:0] quoc [0:DIV_N-1];
    logic [NUM_W:0]   sub;
    remc[0] = num_in;
    denc[0] = den_in;
    quoc[0] = '0;
    for (int i = 1; i < DIV_N; i++) begin
      remc[i] = rem_r[i-1];
      denc[i] = den_r[i-1];
      quoc[i] = quo_r[i-1];
    end
    for (int i = 0; i < DIV_N; i++) begin
      sub = (NUM_W+1)'(denc[i]) << (DIV_N - 1 - i);
      if ({1'b0, remc[i]} >= sub) begin
        rem_nxt[i] = NUM_W'({1'b0, remc[i]} - sub);
        quo_nxt[i] = quoc[i] | (DIV_N'(1) << (DIV_N - 1 - i));
      end else begin
        rem_nxt[i] = remc[i];
        quo_nxt[i] = quoc[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DIV_N; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= (i == 0) ? den_in : den_r[(i == 0) ? 0 : i-1];
        quo_r[i] <= quo_nxt[i];
      end
    end
  end

  assign quo_out = quo_r[DIV_N-1];

endmodule

// ===== sv/psp_obuf.sv =====
// Two-entry output buffer that decouples the pipeline from the result stall.
// The pipeline advances while the buffer has a free entry. Depends on psp_pkg.
module psp_obuf import psp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  out_t push_data,
  input  logic out_stall,
  output logic out_valid,
  output out_t out_data,
  output logic full
);

  out_t       head_r, head_nxt;
  out_t       tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;
  assign full      = (cnt_r == 2'd2);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (pop && push) begin
      if (cnt_r == 2'd1) begin
        head_nxt = push_data;
      end else begin
        head_nxt = tail_r;
        tail_nxt = push_data;
      end
    end else if (pop) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        head_nxt = push_data;
      end else begin
        tail_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

// ===== sv/point_spherical_projection.sv =====
// A point accepted on in_valid passes the pipeline stages and the output buffer
// before out_valid. One point per cycle while the buffer has room: the 32-stage
// square root and two chained 24-stage CORDICs all take a new point each cycle.
// Reset (synchronous, rst_n low) clears all valid bits and the output buffer,
// and loads the projection radius with 1408 (5.5 m).
module point_spherical_projection import psp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  logic        adv;
  logic        full;
  logic        push;
  logic [14:0] radius_r;

  logic        vld_r  [1:LAST_STG];
  meta_t       meta_r [1:LAST_STG];
  meta_t       meta_in;

  logic [30:0] sqx_r, sqy_r, sqz_r;
  logic [31:0] s_r;
  logic [41:0] uzk_r [2:25];

  logic signed [CORDIC_W-1:0] c1_x;
  logic        [ANG_W-1:0]    c1_ang;
  logic signed [CORDIC_W-1:0] c2_x;
  logic        [ANG_W-1:0]    c2_ang;

  logic [15:0] az_r  [26:LAST_STG];
  logic [14:0] pol_r [50:LAST_STG];
  logic [15:0] rng_r [35:LAST_STG];
  logic [15:0] az_nxt;
  logic [14:0] pol_nxt;
  logic [15:0] rng_nxt;

  logic [31:0]      q;
  logic [31:0]      den_r;
  logic [NUM_W-1:0] nx_r, ny_r, nz_r;
  logic [DIV_N-1:0] qx, qy, qz;
  out_t             res;

  assign adv       = !full;
  assign in_stall  = full;
  assign cfg_ready = 1'b1;
  assign push      = vld_r[LAST_STG] && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius_r <= cfg_data;
    end
  end

  always_comb begin
    logic [16:0] sx17, sy17, sz17;
    sx17 = {in_data.point_x[15], in_data.point_x};
    sy17 = {in_data.point_y[15], in_data.point_y};
    sz17 = {in_data.point_z[15], in_data.point_z};
    meta_in.last = in_data.last_in_cloud;
    meta_in.sx   = sx17[16];
    meta_in.sy   = sy17[16];
    meta_in.sz   = sz17[16];
    meta_in.zx   = (in_data.point_x == 16'sd0);
    meta_in.zy   = (in_data.point_y == 16'sd0);
    meta_in.zz   = (in_data.point_z == 16'sd0);
    meta_in.ux   = sx17[16] ? (17'd0 - sx17) : sx17;
    meta_in.uy   = sy17[16] ? (17'd0 - sy17) : sy17;
    meta_in.uz   = sz17[16] ? (17'd0 - sz17) : sz17;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= LAST_STG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[1] <= in_valid;
      for (int k = 2; k <= LAST_STG; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 1 squares, stage 2 sum of squares and gain-scaled |z|.
  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[1] <= meta_in;
      for (int k = 2; k <= LAST_STG; k++) begin
        meta_r[k] <= meta_r[k-1];
      end
      sqx_r    <= 31'(meta_in.ux * meta_in.ux);
      sqy_r    <= 31'(meta_in.uy * meta_in.uy);
      sqz_r    <= 31'(meta_in.uz * meta_in.uz);
      s_r      <= 32'({2'b00, sqx_r} + {2'b00, sqy_r} + {2'b00, sqz_r});
      uzk_r[2] <= 42'(meta_r[1].uz * CORDIC_GAIN_Q24);
      for (int k = 3; k <= 25; k++) begin
        uzk_r[k] <= uzk_r[k-1];
      end
    end
  end

  // Azimuth: first-quadrant angle of (|x|, |y|); its magnitude output is
  // K * sqrt(x^2 + y^2), which feeds the polar-angle CORDIC.
  psp_cordic u_cordic_az (
    .clk     (clk),
    .adv     (adv),
    .x_in    ($signed({7'd0, meta_r[1].ux, 24'd0})),
    .y_in    ($signed({7'd0, meta_r[1].uy, 24'd0})),
    .x_out   (c1_x),
    .ang_out (c1_ang)
  );

  psp_cordic u_cordic_pol (
    .clk     (clk),
    .adv     (adv),
    .x_in    ($signed({6'd0, uzk_r[25]})),
    .y_in    (c1_x),
    .x_out   (c2_x),
    .ang_out (c2_ang)
  );

  always_comb begin
    logic [ANG_W-1:0] a, af;
    logic [ANG_W:0]   sum;
    logic [15:0]      mag;
    if (meta_r[25].zy) begin
      a = '0;
    end else if (meta_r[25].zx) begin
      a = ANG_HALF_PI;
    end else begin
      a = c1_ang;
    end
    af  = meta_r[25].sx ? (ANG_PI - a) : a;
    sum = {1'b0, af} + 33'h0_0000_8000;
    mag = sum[31:16];
    if (meta_r[25].sy) begin
      az_nxt = 16'd0 - mag;
    end else begin
      az_nxt = mag[15] ? 16'h7FFF : mag;
    end
  end

  always_comb begin
    logic [ANG_W-1:0] a, af;
    logic [ANG_W:0]   sum;
    logic [15:0]      mag;
    if (meta_r[49].zx && meta_r[49].zy) begin
      a = '0;
    end else if (meta_r[49].zz) begin
      a = ANG_HALF_PI;
    end else begin
      a = c2_ang;
    end
    af      = meta_r[49].sz ? (ANG_PI - a) : a;
    sum     = {1'b0, af} + 33'h0_0000_8000;
    mag     = sum[31:16];
    pol_nxt = mag[15] ? 15'h7FFF : mag[14:0];
  end

  psp_sqrt u_sqrt (
    .clk      (clk),
    .adv      (adv),
    .s_in     (s_r),
    .root_out (q)
  );

  always_comb begin
    logic [32:0] rsum;
    rsum    = {1'b0, q} + 33'h0_0000_8000;
    rng_nxt = rsum[31:16];
  end

  // Stage 35 forms radius * |c| scaled by 2^17 so the quotient carries a half bit.
  always_ff @(posedge clk) begin
    logic [31:0] px, py, pz;
    px = 32'(radius_r * meta_r[34].ux);
    py = 32'(radius_r * meta_r[34].uy);
    pz = 32'(radius_r * meta_r[34].uz);
    if (adv) begin
      az_r[26] <= az_nxt;
      for (int k = 27; k <= LAST_STG; k++) begin
        az_r[k] <= az_r[k-1];
      end
      pol_r[50]       <= pol_nxt;
      pol_r[LAST_STG] <= pol_r[50];
      rng_r[35]       <= rng_nxt;
      for (int k = 36; k <= LAST_STG; k++) begin
        rng_r[k] <= rng_r[k-1];
      end
      den_r <= q;
      nx_r  <= {px[29:0], 17'd0};
      ny_r  <= {py[29:0], 17'd0};
      nz_r  <= {pz[29:0], 17'd0};
    end
  end

  psp_div u_div_x (.clk(clk), .adv(adv), .num_in(nx_r), .den_in(den_r), .quo_out(qx));
  psp_div u_div_y (.clk(clk), .adv(adv), .num_in(ny_r), .den_in(den_r), .quo_out(qy));
  psp_div u_div_z (.clk(clk), .adv(adv), .num_in(nz_r), .den_in(den_r), .quo_out(qz));

  always_comb begin
    logic [16:0] tx, ty, tz;
    logic [15:0] mx, my, mz;
    tx = {1'b0, qx} + 17'd1;
    ty = {1'b0, qy} + 17'd1;
    tz = {1'b0, qz} + 17'd1;
    mx = tx[16:1];
    my = ty[16:1];
    mz = tz[16:1];
    res.last_out    = meta_r[LAST_STG].last;
    res.azimuth     = az_r[LAST_STG];
    res.polar_angle = pol_r[LAST_STG];
    res.range       = rng_r[LAST_STG];
    if (meta_r[LAST_STG].zx && meta_r[LAST_STG].zy && meta_r[LAST_STG].zz) begin
      // The origin projects onto the sphere's pole.
      res.proj_x = '0;
      res.proj_y = '0;
      res.proj_z = $signed({1'b0, radius_r});
    end else begin
      res.proj_x = meta_r[LAST_STG].sx ? (16'd0 - mx) : mx;
      res.proj_y = meta_r[LAST_STG].sy ? (16'd0 - my) : my;
      res.proj_z = meta_r[LAST_STG].sz ? (16'd0 - mz) : mz;
    end
  end

  psp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (full)
  );

endmodule

// ===== tb/point_spherical_projection_tb.sv =====
// Testbench for point_spherical_projection: a directed table, then random
// points under several sphere radii, checked against an integer predictor.
// Depends on psp_pkg and the point_spherical_projection RTL.
module point_spherical_projection_tb import psp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_STEPS = 40;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint unsigned Q62_ONE = 64'd1 << 62;
  localparam longint unsigned INV_PI_Q64 = 64'h517C_C1B7_2722_0A95;
  localparam longint unsigned HALF_TURN = 64'd1 << 47;
  localparam longint unsigned QUARTER_TURN = 64'd1 << 46;

  typedef struct {
    in_t  pt;
    bit   typed;
    out_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [14:0] cfg_data = '0;

  longint unsigned atan_q47 [ANGLE_STEPS];
  logic [14:0] radius;
  out_t        pending [$];
  row_t        rows [$];
  int          errors = 0;
  int          cycles = 0;

  point_spherical_projection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned atan_inv_q62(longint unsigned n);
    longint unsigned p, n2, sum, k, t;
    bit sub;
    p = Q62_ONE / n;
    n2 = n * n;
    sum = 0;
    k = 0;
    sub = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      sum = sub ? sum - t : sum + t;
      sub = !sub;
      p = p / n2;
      k++;
    end
    return sum;
  endfunction

  function automatic void build_atan_table();
    longint unsigned r, hi;
    logic [127:0] prod;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      if (i == 0) r = 4 * atan_inv_q62(5) - atan_inv_q62(239);
      else if (i <= 30) r = atan_inv_q62(64'd1 << i);
      else r = Q62_ONE >> i;
      prod = 128'(r) * 128'(INV_PI_Q64);
      hi = prod[127:64];
      atan_q47[i] = (hi + (64'd1 << 14)) >> 15;
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC, angle in [0, pi/2] with pi = 2^47.
  function automatic longint unsigned vector_angle(longint unsigned ax, longint unsigned ay);
    longint cx, cy, dx, dy, acc;
    if (ay == 0) return 0;
    if (ax == 0) return QUARTER_TURN;
    cx = longint'(ax << 24);
    cy = longint'(ay << 24);
    acc = 0;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; acc += longint'(atan_q47[i]);
      end else begin
        cx -= dx; cy += dy; acc -= longint'(atan_q47[i]);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(QUARTER_TURN)) acc = longint'(QUARTER_TURN);
    return longint'(acc);
  endfunction

  function automatic longint unsigned angle_to_lsb(longint unsigned a);
    return (a + (64'd1 << 31)) >> 32;
  endfunction

  // Rounds rad * c / sqrt(s), ties away from zero, to a 16-bit pattern.
  function automatic logic [15:0] scale_to_sphere(longint unsigned rad, int c,
                                                  longint unsigned s);
    longint unsigned m, a, n;
    m = longint'(c < 0 ? -c : c);
    a = rad * rad * m * m;
    n = int_sqrt(a / s);
    if (4 * a >= (2 * n + 1) * (2 * n + 1) * s) n++;
    if (c < 0) n = 64'd0 - n;
    return n[15:0];
  endfunction

  function automatic out_t project_point(in_t p);
    out_t o;
    int x, y, z;
    longint unsigned ux, uy, uz, sxy, s, r, a, mag, rho;
    x = p.point_x;
    y = p.point_y;
    z = p.point_z;
    ux = longint'(x < 0 ? -x : x);
    uy = longint'(y < 0 ? -y : y);
    uz = longint'(z < 0 ? -z : z);
    sxy = ux * ux + uy * uy;
    s = sxy + uz * uz;
    o = '0;
    o.last_out = p.last_in_cloud;
    if (s == 0) begin
      o.proj_z = {1'b0, radius};
      return o;
    end
    r = int_sqrt(s);
    if (s - r * r > r) r++;
    o.range = r[15:0];
    a = vector_angle(ux << 16, uy << 16);
    if (x < 0) a = HALF_TURN - a;
    mag = angle_to_lsb(a);
    if (y < 0) begin
      mag = 64'd0 - mag;
      o.azimuth = mag[15:0];
    end else begin
      if (mag > 32767) mag = 32767;
      o.azimuth = mag[15:0];
    end
    rho = int_sqrt(sxy << 32);
    a = vector_angle(uz << 16, rho);
    if (z < 0) a = HALF_TURN - a;
    mag = angle_to_lsb(a);
    if (mag > 32767) mag = 32767;
    o.polar_angle = mag[14:0];
    o.proj_x = scale_to_sphere(radius, x, s);
    o.proj_y = scale_to_sphere(radius, y, s);
    o.proj_z = scale_to_sphere(radius, z, s);
    return o;
  endfunction

  // One LSB of rounding slack is allowed, with wraparound at the field width.
  function automatic bit near(logic [15:0] want, logic [15:0] got, logic [15:0] mask);
    logic [15:0] d;
    d = (want - got) & mask;
    return d == 0 || d == 1 || d == mask;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got,
                                      logic [15:0] mask);
    if (!near(want, got, mask)) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stall pattern: alternates between no stalls, random stalls and
  // a fixed one-in-three stall.
  always @(posedge clk) begin
    case ((cycles / 64) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= (cycles % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        want = pending.pop_front();
        check_field("azimuth", want.azimuth, out_data.azimuth, 16'hFFFF);
        check_field("polar_angle", {1'b0, want.polar_angle},
                    {1'b0, out_data.polar_angle}, 16'h7FFF);
        check_field("range", want.range, out_data.range, 16'hFFFF);
        check_field("proj_x", want.proj_x, out_data.proj_x, 16'hFFFF);
        check_field("proj_y", want.proj_y, out_data.proj_y, 16'hFFFF);
        check_field("proj_z", want.proj_z, out_data.proj_z, 16'hFFFF);
        if (want.last_out !== out_data.last_out) begin
          $error("last_out: expected %0d, got %0d", want.last_out, out_data.last_out);
          errors++;
        end
      end
    end
  end

  task automatic add_row(int x, int y, int z, bit last, bit typed, out_t want);
    row_t r;
    r.pt.point_x = x[15:0];
    r.pt.point_y = y[15:0];
    r.pt.point_z = z[15:0];
    r.pt.last_in_cloud = last;
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endtask

  function automatic out_t known(int az, int pol, int rng, int px, int py, int pz, bit last);
    out_t o;
    o.azimuth = az[15:0];
    o.polar_angle = pol[14:0];
    o.range = rng[15:0];
    o.proj_x = px[15:0];
    o.proj_y = py[15:0];
    o.proj_z = pz[15:0];
    o.last_out = last;
    return o;
  endfunction

  // Sends one point, bursting with random gaps.
  task automatic send_point(in_t p, bit typed, out_t want);
    out_t exp_res;
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_res = typed ? want : project_point(p);
    pending = {pending, exp_res};
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic set_radius(logic [14:0] value);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    radius = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t random_point();
    in_t p;
    p = '0;
    p.last_in_cloud = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        p.point_x = 16'($urandom); p.point_y = 16'($urandom); p.point_z = 16'($urandom);
      end
      3: begin
        p.point_x = 16'($urandom_range(0, 512) - 256);
        p.point_y = 16'($urandom_range(0, 512) - 256);
        p.point_z = 16'($urandom_range(0, 512) - 256);
      end
      4: begin
        // Each coordinate is zero or random: the origin, an axis, a plane or anywhere.
        p.point_x = ($urandom_range(0, 1)) ? 16'($urandom) : 16'd0;
        p.point_y = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd0;
        p.point_z = ($urandom_range(0, 1)) ? 16'($urandom) : 16'd0;
      end
      default: begin
        p.point_x = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7FFF;
        p.point_y = ($urandom_range(0, 1)) ? 16'h8000 : 16'($urandom);
        p.point_z = ($urandom_range(0, 1)) ? 16'h7FFF : 16'($urandom);
      end
    endcase
    return p;
  endfunction

  initial begin
    out_t none;
    logic [14:0] radii [5];
    none = '0;
    radius = RADIUS_RESET;
    build_atan_table();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(0, 0, 0, 1, 1, known(0, 0, 0, 0, 0, 1408, 1));
    add_row(256, 0, 0, 0, 1, known(0, 16384, 256, 1408, 0, 0, 0));
    add_row(-256, 0, 0, 0, 1, known(32767, 16384, 256, -1408, 0, 0, 0));
    add_row(0, 0, 256, 1, 1, known(0, 0, 256, 0, 0, 1408, 1));
    add_row(0, 0, -256, 0, 1, known(0, 32767, 256, 0, 0, -1408, 0));
    add_row(0, 256, 0, 0, 0, none);
    add_row(0, -256, 0, 0, 0, none);
    add_row(-256, -1, 0, 0, 0, none);
    add_row(-256, 1, 0, 0, 0, none);
    add_row(32767, 32767, 32767, 0, 0, none);
    add_row(-32768, -32768, -32768, 1, 0, none);
    add_row(-32768, 0, 0, 0, 0, none);
    add_row(0, -32768, 0, 0, 0, none);
    add_row(0, 0, -32768, 0, 0, none);
    add_row(1, 0, 0, 0, 0, none);
    add_row(-1, -1, -1, 0, 0, none);
    add_row(300, 400, 0, 0, 0, none);
    add_row(-300, 400, -1200, 1, 0, none);
    add_row(32767, -32768, 1, 0, 0, none);
    add_row(1, 1, 32767, 0, 0, none);
    foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].want);

    radii[0] = 15'h7FFF;
    radii[1] = 15'd0;
    radii[2] = 15'($urandom);
    radii[3] = 15'($urandom_range(1, 4000));
    radii[4] = RADIUS_RESET;
    foreach (radii[k]) begin
      set_radius(radii[k]);
      repeat (80) send_point(random_point(), 1'b0, none);
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
